@@ src/assert_macros.svh @@
// Assertion macros for the mtf1 RTL files; only mtf1_dp includes them.
// Bodies assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/mtf1_pkg.sv @@
// Shared constants, controller states and command/status types for the MTF-1 coder.
// No dependencies.
`default_nettype none
package mtf1_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int BYTE_W        = 8;
  localparam int AW            = $clog2(ALPHABET_SIZE);
  localparam int CW            = $clog2(ALPHABET_SIZE + 1);

  localparam logic [BYTE_W:0] KEY_LIM = (BYTE_W + 1)'(ALPHABET_SIZE);
  localparam logic [AW-1:0]   LAST_IDX = AW'(ALPHABET_SIZE - 1);
  localparam logic [CW-1:0]   CNT_LIM  = CW'(ALPHABET_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_PICK,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_CNT,
    RD_KEY,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    take;
    logic    res_clr;
    logic    wr_shift;
    logic    wr_put;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic dir;
    logic key_ok;
    logic hit;
    logic scan_end;
    logic cnt_ok;
    logic hit_zero;
    logic shift_done;
    logic rd_ok;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/mtf1_ctrl.sv @@
// Controller state machine: sequences list scan, fetch, shift and result hand-off.
// Depends on mtf1_pkg.
`default_nettype none
module mtf1_ctrl
  import mtf1_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_CNT;
    in_stall  = !rst_n || (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.accept  = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = stat.dir ? S_FETCH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.key_ok) begin
          cmd.res_clr = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.hit) begin
          cmd.take  = 1'b1;
          state_nxt = stat.hit_zero ? S_DONE : S_SHIFT;
        end else if (stat.scan_end) begin
          cmd.res_clr = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.cnt_ok) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_CNT;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FETCH: begin
        if (!stat.key_ok) begin
          cmd.res_clr = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_KEY;
          state_nxt  = S_PICK;
        end
      end
      S_PICK: begin
        cmd.take  = 1'b1;
        state_nxt = stat.hit_zero ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        cmd.wr_shift = stat.rd_ok;
        if (stat.shift_done) begin
          state_nxt = S_PUT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PREV;
          cmd.cnt_dec = 1'b1;
        end
      end
      S_PUT: begin
        cmd.wr_put = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/mtf1_dp.sv @@
// Datapath: symbol list memory with valid bits, address counter, item and result registers.
// Depends on mtf1_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mtf1_dp
  import mtf1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_block_end,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_block_end_out,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat
);

  logic [BYTE_W-1:0] list_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;

  logic              dir_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  logic [CW-1:0]     cnt_r;
  logic [BYTE_W-1:0] key_r;
  logic              last_r;
  logic [AW-1:0]     rd_addr_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     pos_r;
  logic [BYTE_W-1:0] sym_r;
  logic [BYTE_W-1:0] res_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] ent;
  logic              pos_one;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  always_comb begin
    case (cmd.rd_sel)
      RD_CNT:  rd_addr = cnt_r[AW-1:0];
      RD_KEY:  rd_addr = key_r[AW-1:0];
      RD_PREV: rd_addr = cnt_r[AW-1:0] - AW'(1);
      default: rd_addr = '0;
    endcase
  end

  assign ent     = rd_vld_r ? rd_data_r : BYTE_W'(rd_addr_r);
  assign pos_one = (pos_r == AW'(1));
  assign wr_en   = cmd.wr_shift | cmd.wr_put;
  assign wr_addr = cmd.wr_put ? (pos_one ? AW'(0) : AW'(1)) : (rd_addr_r + AW'(1));
  assign wr_data = cmd.wr_put ? sym_r : ent;

  assign stat.dir        = dir_r;
  assign stat.key_ok     = ({1'b0, key_r} < KEY_LIM);
  assign stat.hit        = rd_ok_r && (ent == key_r);
  assign stat.scan_end   = rd_ok_r && (ent != key_r) && (rd_addr_r == LAST_IDX);
  assign stat.cnt_ok     = (cnt_r < CNT_LIM);
  assign stat.hit_zero   = (rd_addr_r == '0);
  assign stat.shift_done = (cnt_r == (pos_one ? CW'(0) : CW'(1)));
  assign stat.rd_ok      = rd_ok_r;
  assign stat.out_busy   = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
      rd_ok_r <= cmd.rd_en;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.out_load && last_r) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.take) begin
        cnt_r <= CW'(rd_addr_r);
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= list_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r  <= in_byte;
      last_r <= in_block_end;
    end
    if (cmd.rd_en) begin
      rd_addr_r <= rd_addr;
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.take) begin
      pos_r <= rd_addr_r;
      sym_r <= ent;
      res_r <= dir_r ? ent : BYTE_W'(rd_addr_r);
    end else if (cmd.res_clr) begin
      res_r <= '0;
    end
    if (cmd.out_load) begin
      out_byte_r <= res_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_block_end_out = out_last_r;

  `ASSERT_CLK(a_no_rw_clash, (wr_en && cmd.rd_en) |-> (wr_addr != rd_addr), "list read and write hit one entry")
  `ASSERT_CLK(a_no_overwrite, cmd.out_load |-> !(out_valid_r && out_stall), "result loaded over a stalled beat")
  `ASSERT_CLK(a_take_has_data, cmd.take |-> rd_ok_r, "entry taken without a read in flight")
  `ASSERT_CLK(a_shift_has_data, cmd.wr_shift |-> rd_ok_r, "shift write without read data")
  `ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_r, "loaded result not presented")

endmodule
`default_nettype wire

@@ src/move_to_front_mtf1_codec.sv @@
// A stalled output holds the result in the done state until the previous beat is taken.
// One item at a time; the next item can be accepted in the cycle after the result is loaded.
// Throughput: one list entry scanned, then one shifted, per cycle (one read, one write port).
// Reset (rst_n, synchronous, active low) clears control, direction, and all list valid bits,
// so the list reads as identity order at once; the valid bits clear again when a block-end result is loaded.
`default_nettype none
module move_to_front_mtf1_codec
  import mtf1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_block_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_block_end_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtf1_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtf1_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_byte           (in_byte),
    .in_block_end      (in_block_end),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_block_end_out (out_block_end_out),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
`default_nettype wire
